// ----- sv/tbae_pkg.sv -----
// ----------------------------------------------------------------------------
// tbae_pkg
// Shared types, constants and helpers for the texture budget aging evictor.
// ----------------------------------------------------------------------------
package tbae_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam logic [31:0] BUDGET_RESET = 32'd268435456;

   localparam logic [1:0] REQ_TICK     = 2'd0;
   localparam logic [1:0] REQ_TOUCH    = 2'd1;
   localparam logic [1:0] REQ_EXCHANGE = 2'd2;
   localparam logic [1:0] REQ_RELEASE  = 2'd3;

   localparam logic KIND_NOTICE = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SCAN_END,
      ST_NOTICE,
      ST_FIT,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic load_req;
      logic tick;
      logic touch;
      logic mark;
      logic admit;
      logic free_req;
      logic scan_clear;
      logic scan_step;
      logic evict;
      logic set_ok;
      logic ok_val;
      logic emit;
      logic emit_kind;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       slot_valid;
      logic       slot_resident;
      logic       fits;
      logic       found;
      logic       scan_last;
      logic       out_free;
   } status_type;

   function automatic logic [5:0] popcount32(input logic [31:0] v);
      logic [31:0] t;
      t = (v & 32'h55555555) + ((v >> 1) & 32'h55555555);
      t = (t & 32'h33333333) + ((t >> 2) & 32'h33333333);
      t = (t & 32'h0f0f0f0f) + ((t >> 4) & 32'h0f0f0f0f);
      t = (t & 32'h00ff00ff) + ((t >> 8) & 32'h00ff00ff);
      t = (t & 32'h0000ffff) + ((t >> 16) & 32'h0000ffff);
      return t[5:0];
   endfunction

endpackage

// ----- sv/tbae_if.sv -----
// ----------------------------------------------------------------------------
// tbae_req_if / tbae_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface tbae_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [3:0]  slot;
   logic [31:0] size_bytes;
   modport source (output valid, req_type, slot, size_bytes, input ready);
   modport sink (input valid, req_type, slot, size_bytes, output ready);
endinterface

interface tbae_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [3:0]  target_slot;
   logic        success;
   logic [31:0] resident_total;
   logic        last;
   modport source (output valid, kind, target_slot, success, resident_total, last,
                   input ready);
   modport sink (input valid, kind, target_slot, success, resident_total, last,
                 output ready);
endinterface

// ----- sv/tbae_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbae_ctrl
// Request sequencer: decode, eviction scan loop and result transfers.
// ----------------------------------------------------------------------------
module tbae_ctrl
   import tbae_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.set_ok = 1'b1;
            state_in   = ST_STATUS;
            case (st.req_type)
               REQ_TICK: begin
                  cmd.tick   = 1'b1;
                  cmd.ok_val = 1'b1;
               end
               REQ_TOUCH: begin
                  cmd.touch  = st.slot_valid;
                  cmd.ok_val = 1'b1;
               end
               REQ_RELEASE: begin
                  cmd.free_req = st.slot_valid && st.slot_resident;
                  cmd.ok_val   = st.slot_valid && st.slot_resident;
               end
               REQ_EXCHANGE: begin
                  if (!st.slot_valid) begin
                     cmd.ok_val = 1'b0;
                  end else if (st.slot_resident) begin
                     cmd.mark   = 1'b1;
                     cmd.ok_val = 1'b1;
                  end else if (st.fits) begin
                     cmd.admit  = 1'b1;
                     cmd.ok_val = 1'b1;
                  end else begin
                     cmd.ok_val     = 1'b0;
                     cmd.scan_clear = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               default: begin
                  cmd.ok_val = 1'b0;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            if (st.found) begin
               cmd.evict = 1'b1;
               state_in  = ST_NOTICE;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_NOTICE: begin
            if (st.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_NOTICE;
               state_in      = ST_FIT;
            end
         end
         ST_FIT: begin
            if (st.fits) begin
               cmd.admit  = 1'b1;
               cmd.set_ok = 1'b1;
               cmd.ok_val = 1'b1;
               state_in   = ST_STATUS;
            end else begin
               cmd.scan_clear = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_STATUS: begin
            if (st.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_STATUS;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/tbae_dp.sv -----
// ----------------------------------------------------------------------------
// tbae_dp
// Residency table, budget, ranking scan and result register.
// ----------------------------------------------------------------------------
module tbae_dp
   import tbae_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic [1:0]  in_req_type,
   input  logic [3:0]  in_slot,
   input  logic [31:0] in_size_bytes,
   input  cmd_type     cmd,
   output status_type  st,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [3:0]  rsp_target_slot,
   output logic        rsp_success,
   output logic [31:0] rsp_resident_total,
   output logic        rsp_last
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int OW = $clog2(SLOTS + 1);

   logic [31:0]   budget_ff;
   logic [1:0]    rtype_ff;
   logic [3:0]    slot_ff;
   logic [31:0]   size_ff;
   logic          ok_ff;

   logic [SLOTS-1:0] resident_ff;
   logic [SLOTS-1:0] admitted_ff;
   logic [31:0]      history_ff [SLOTS];
   logic [31:0]      rsize_ff [SLOTS];
   logic [OW-1:0]    order_ff [SLOTS];
   logic [OW-1:0]    count_ff;
   logic [31:0]      bytes_ff;

   logic [IW-1:0] idx_ff;
   logic          found_ff;
   logic [IW-1:0] best_ff;
   logic [37:0]   best_key_ff;
   logic [OW-1:0] best_order_ff;

   logic          out_valid_ff;
   logic          out_kind_ff;
   logic [3:0]    out_slot_ff;
   logic          out_ok_ff;
   logic [31:0]   out_total_ff;

   logic [IW-1:0] sidx;
   logic          slot_valid;
   logic [IW-1:0] free_idx;
   logic [OW-1:0] free_rank;
   logic          do_free;
   logic [37:0]   key;
   logic          cand;
   logic          better;
   logic          out_free;

   assign sidx       = IW'(slot_ff);
   assign slot_valid = 32'(slot_ff) < SLOTS;
   assign do_free    = cmd.free_req || cmd.evict;
   assign free_idx   = cmd.evict ? best_ff : sidx;
   assign free_rank  = order_ff[free_idx];
   assign key        = 38'(popcount32(history_ff[idx_ff])) * 38'(rsize_ff[idx_ff]);
   assign cand       = resident_ff[idx_ff] && !admitted_ff[idx_ff] && (idx_ff != sidx);
   assign better     = !found_ff || (key < best_key_ff) ||
                       ((key == best_key_ff) && (order_ff[idx_ff] < best_order_ff));
   assign out_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      st               = '0;
      st.req_type      = rtype_ff;
      st.slot_valid    = slot_valid;
      st.slot_resident = resident_ff[sidx];
      st.fits          = ({1'b0, bytes_ff} + {1'b0, size_ff}) <= {1'b0, budget_ff};
      st.found         = found_ff;
      st.scan_last     = idx_ff == IW'(SLOTS - 1);
      st.out_free      = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
      end else if (csr_we) begin
         budget_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rtype_ff <= in_req_type;
         slot_ff  <= in_slot;
         size_ff  <= in_size_bytes;
      end
      if (cmd.set_ok) begin
         ok_ff <= cmd.ok_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resident_ff <= '0;
         admitted_ff <= '0;
         count_ff    <= '0;
         bytes_ff    <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            history_ff[i] <= '0;
         end
      end else begin
         if (cmd.tick) begin
            admitted_ff <= '0;
            for (int i = 0; i < SLOTS; i++) begin
               if (resident_ff[i]) begin
                  history_ff[i] <= {history_ff[i][30:0], 1'b0};
               end
            end
         end
         if (cmd.touch) begin
            history_ff[sidx][0] <= 1'b1;
         end
         if (cmd.mark) begin
            admitted_ff[sidx] <= 1'b1;
         end
         if (cmd.admit) begin
            resident_ff[sidx] <= 1'b1;
            admitted_ff[sidx] <= 1'b1;
            rsize_ff[sidx]    <= size_ff;
            order_ff[sidx]    <= count_ff;
            count_ff          <= count_ff + 1'b1;
            bytes_ff          <= bytes_ff + size_ff;
         end
         if (do_free) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (resident_ff[i] && (order_ff[i] > free_rank)) begin
                  order_ff[i] <= order_ff[i] - 1'b1;
               end
            end
            bytes_ff              <= bytes_ff - rsize_ff[free_idx];
            resident_ff[free_idx] <= 1'b0;
            admitted_ff[free_idx] <= 1'b0;
            if (count_ff != '0) begin
               count_ff <= count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (cmd.scan_clear) begin
         found_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (cand && better) begin
            found_ff      <= 1'b1;
            best_ff       <= idx_ff;
            best_key_ff   <= key;
            best_order_ff <= order_ff[idx_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_kind_ff  <= cmd.emit_kind;
         out_slot_ff  <= (cmd.emit_kind == KIND_STATUS) ? slot_ff : 4'(best_ff);
         out_ok_ff    <= (cmd.emit_kind == KIND_STATUS) ? ok_ff : 1'b1;
         out_total_ff <= bytes_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_target_slot    = out_slot_ff;
   assign rsp_success        = out_ok_ff;
   assign rsp_resident_total = out_total_ff;
   assign rsp_last           = out_kind_ff;

endmodule

// ----- sv/texture_budget_aging_evictor_top.sv -----
// ----------------------------------------------------------------------------
// texture_budget_aging_evictor_top
// Texture residency table under a byte budget with aging-based eviction.
//
// Requests (tick, touch, exchange, release) arrive on the req channel, one
// at a time. Each request yields zero or more eviction notices followed by
// one status result (last high) on the rsp channel. The budget register is
// written through csr_we/csr_wdata; the user must write it only while the
// block is idle, and the block itself does not enforce this. An exchange
// that must evict runs a ranking scan, one slot per cycle through a
// popcount-times-size multiplier, then emits a notice and repeats the fit
// test, once per eviction. The next request is taken once the status
// result is loaded into the output register.
// Reset clears the table, the totals and the output valid, and restores the
// budget to 256 MiB. A stalled receiver holds the result register and the
// sequencer waits before loading the next result.
// ----------------------------------------------------------------------------
module texture_budget_aging_evictor_top
   import tbae_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   tbae_req_if.sink    req,
   tbae_rsp_if.source  rsp
);

   cmd_type    cmd;
   status_type st;
   logic       req_ready;

   assign req.ready = req_ready;

   tbae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   tbae_dp #(.SLOTS(SLOTS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .in_req_type        (req.req_type),
      .in_slot            (req.slot),
      .in_size_bytes      (req.size_bytes),
      .cmd                (cmd),
      .st                 (st),
      .rsp_ready          (rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_kind           (rsp.kind),
      .rsp_target_slot    (rsp.target_slot),
      .rsp_success        (rsp.success),
      .rsp_resident_total (rsp.resident_total),
      .rsp_last           (rsp.last)
   );

endmodule

// ----- sv/tbae_checker.sv -----
// ----------------------------------------------------------------------------
// tbae_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tbae_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic        rsp_success,
   input logic        rsp_last,
   input logic [31:0] rsp_resident_total
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_resident_total))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_notice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> !rsp_last && rsp_success)
      else $error("eviction notice malformed");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last)
      else $error("status without last");

endmodule

bind texture_budget_aging_evictor_top tbae_checker u_tbae_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_kind           (rsp.kind),
   .rsp_success        (rsp.success),
   .rsp_last           (rsp.last),
   .rsp_resident_total (rsp.resident_total)
);
